[design/i2cbs_pkg.sv]
// ----------------------------------------------------------------------------
// i2cbs_pkg: shared types and constants
// Command codes, transfer payload structs and the phase table of the
// I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

    localparam int SHORT_W  = 16;
    localparam int LONG_W   = 20;
    localparam int PHASE_W  = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [2:0] CMD_NONE     = 3'd0;
    localparam logic [2:0] CMD_START    = 3'd1;
    localparam logic [2:0] CMD_STOP     = 3'd2;
    localparam logic [2:0] CMD_WRITE    = 3'd3;
    localparam logic [2:0] CMD_READ     = 3'd4;
    localparam logic [2:0] CMD_WAIT_ACK = 3'd5;
    localparam logic [2:0] CMD_ACK      = 3'd6;
    localparam logic [2:0] CMD_NACK     = 3'd7;

    localparam logic [CFG_IDX_W-1:0] REG_SHORT_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_DELAY  = 2'd1;

    localparam logic [SHORT_W-1:0] SHORT_RESET = 16'd10;
    localparam logic [LONG_W-1:0]  LONG_RESET  = 20'd180;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] write_data;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive_enable;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_received;
        logic       rejected;
    } res_item_t;

    // last phase index of each command sequence
    function automatic logic [PHASE_W-1:0] last_phase(input logic [2:0] cmd);
        logic [PHASE_W-1:0] p;
        unique case (cmd)
            CMD_NONE:     p = 5'd0;
            CMD_START:    p = 5'd3;
            CMD_STOP:     p = 5'd3;
            CMD_WRITE:    p = 5'd25;
            CMD_READ:     p = 5'd16;
            CMD_WAIT_ACK: p = 5'd3;
            CMD_ACK:      p = 5'd4;
            CMD_NACK:     p = 5'd3;
            default:      p = 5'd0;
        endcase
        return p;
    endfunction

endpackage

[design/i2c_master_bit_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer: I2C master bit-level phase sequencer
// Turns start, stop, byte and ack commands into timed SCL/SDA phases,
// one input transfer per bus tick.
// ----------------------------------------------------------------------------
//  channel  | ports                          | payload
//  ---------+--------------------------------+----------------------------
//  input    | s_valid, s_ready, s_data       | in_item_t (req, byte, sda)
//  result   | m_valid, m_ready, m_data       | res_item_t (pins, status)
//  config   | cfg_valid, cfg_ready           | cfg_index, cfg_data
//
//  One tick per cycle while s_valid and s_ready are high: each accepted
//  transfer updates the sequencer state and loads one result in the same cycle.
//  A two-entry output buffer (output register plus skid) keeps s_ready high
//  while one result waits; s_ready drops only when both entries are full.
//  Reset is synchronous, active low; delays return to 10 and 180 ticks.
//  Config writes are always taken (cfg_ready is tied high).
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  i2cbs_pkg::in_item_t            s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output i2cbs_pkg::res_item_t           m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [i2cbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [i2cbs_pkg::LONG_W-1:0]    cfg_data
);
    import i2cbs_pkg::*;

    logic [SHORT_W-1:0] short_delay_reg;
    logic [LONG_W-1:0]  long_delay_reg;

    logic [2:0]         cmd_reg, cmd_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [LONG_W-1:0]  delay_reg, delay_next;
    logic [1:0]         step_reg, step_next;
    logic [7:0]         shift_reg, shift_next;
    logic [7:0]         rbyte_reg, rbyte_next;
    logic               ack_reg, ack_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               dir_reg, dir_next;

    logic               enter;
    logic               long_hold;
    logic               rej;
    logic               done;
    logic [LONG_W-1:0]  hold_sel;
    res_item_t          result;

    res_item_t          out_reg;
    logic               out_valid_reg;
    res_item_t          skid_reg;
    logic               skid_valid_reg;

    logic               accept;
    logic               pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign pop       = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_delay_reg <= SHORT_RESET;
            long_delay_reg  <= LONG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_SHORT_DELAY) begin
                short_delay_reg <= cfg_data[SHORT_W-1:0];
            end else if (cfg_index == REG_LONG_DELAY) begin
                long_delay_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        cmd_next   = cmd_reg;
        phase_next = phase_reg;
        delay_next = delay_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        rbyte_next = rbyte_reg;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        dir_next   = dir_reg;
        enter      = 1'b0;
        long_hold  = 1'b0;
        rej        = 1'b0;
        done       = 1'b0;
        hold_sel   = '0;

        if (cmd_reg == CMD_NONE) begin
            if (s_data.req_type != CMD_NONE) begin
                cmd_next   = s_data.req_type;
                phase_next = '0;
                shift_next = (s_data.req_type == CMD_WRITE) ? s_data.write_data : 8'd0;
                enter      = 1'b1;
            end
        end else begin
            rej = (s_data.req_type != CMD_NONE);
            if (delay_reg > LONG_W'(1)) begin
                delay_next = delay_reg - LONG_W'(1);
            end else if (phase_reg >= last_phase(cmd_reg)) begin
                if (cmd_reg == CMD_READ) begin
                    rbyte_next = shift_reg;
                end
                cmd_next   = CMD_NONE;
                phase_next = '0;
                delay_next = '0;
                done       = 1'b1;
            end else begin
                phase_next = phase_reg + PHASE_W'(1);
                enter      = 1'b1;
            end
        end

        if (enter) begin
            unique case (cmd_next)
                CMD_START: begin
                    if (phase_next == 5'd0) begin
                        dir_next = 1'b1;
                        sda_next = 1'b1;
                    end else if (phase_next == 5'd1) begin
                        scl_next = 1'b1;
                    end else if (phase_next == 5'd2) begin
                        sda_next = 1'b0;
                    end else begin
                        scl_next = 1'b0;
                    end
                end
                CMD_STOP: begin
                    if (phase_next == 5'd0) begin
                        dir_next = 1'b1;
                        scl_next = 1'b0;
                    end else if (phase_next == 5'd1) begin
                        sda_next = 1'b0;
                    end else if (phase_next == 5'd2) begin
                        scl_next = 1'b1;
                    end else begin
                        sda_next = 1'b1;
                    end
                end
                CMD_WRITE: begin
                    if (phase_next == 5'd0) begin
                        dir_next  = 1'b1;
                        scl_next  = 1'b0;
                        step_next = 2'd0;
                    end else if (phase_next >= 5'd25) begin
                        sda_next = 1'b1;
                    end else begin
                        // three phases per bit: set data, raise SCL, drop SCL and shift
                        step_next = (step_reg == 2'd2) ? 2'd0 : step_reg + 2'd1;
                        if (step_reg == 2'd0) begin
                            sda_next = shift_reg[7];
                        end else if (step_reg == 2'd1) begin
                            scl_next = 1'b1;
                        end else begin
                            scl_next   = 1'b0;
                            shift_next = {shift_reg[6:0], 1'b0};
                        end
                    end
                end
                CMD_READ: begin
                    long_hold = 1'b1;
                    if (phase_next == 5'd0) begin
                        dir_next = 1'b0;
                        scl_next = 1'b0;
                    end else if (phase_next[0]) begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        scl_next   = 1'b1;
                    end else begin
                        shift_next = {shift_reg[7:1], shift_reg[0] | s_data.sda_in};
                        scl_next   = 1'b0;
                    end
                end
                CMD_WAIT_ACK: begin
                    if (phase_next == 5'd0) begin
                        dir_next = 1'b0;
                        scl_next = 1'b0;
                    end else if (phase_next == 5'd1) begin
                        sda_next = 1'b1;
                    end else if (phase_next == 5'd2) begin
                        scl_next = 1'b1;
                    end else begin
                        ack_next  = !s_data.sda_in;
                        scl_next  = 1'b0;
                        long_hold = 1'b1;
                    end
                end
                CMD_ACK: begin
                    if (phase_next == 5'd0) begin
                        dir_next = 1'b1;
                        scl_next = 1'b0;
                    end else if (phase_next == 5'd1) begin
                        sda_next = 1'b0;
                    end else if (phase_next == 5'd2) begin
                        scl_next = 1'b1;
                    end else if (phase_next == 5'd3) begin
                        scl_next = 1'b0;
                    end else begin
                        sda_next = 1'b1;
                    end
                end
                CMD_NACK: begin
                    if (phase_next == 5'd0) begin
                        dir_next = 1'b1;
                        scl_next = 1'b0;
                    end else if (phase_next == 5'd1) begin
                        sda_next = 1'b1;
                    end else if (phase_next == 5'd2) begin
                        scl_next = 1'b1;
                    end else begin
                        scl_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase

            hold_sel   = long_hold ? long_delay_reg : LONG_W'(short_delay_reg);
            // a zero hold still lasts one tick
            delay_next = (hold_sel == '0) ? LONG_W'(1) : hold_sel;
        end
    end

    always_comb begin
        result.scl_out          = scl_next;
        result.sda_out          = sda_next;
        result.sda_drive_enable = dir_next;
        result.busy_res         = (cmd_next != CMD_NONE);
        result.done_res         = done;
        result.read_data        = rbyte_next;
        result.ack_received     = ack_next;
        result.rejected         = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= CMD_NONE;
            phase_reg <= '0;
            delay_reg <= '0;
            step_reg  <= '0;
            shift_reg <= '0;
            rbyte_reg <= '0;
            ack_reg   <= 1'b0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            dir_reg   <= 1'b1;
        end else if (accept) begin
            cmd_reg   <= cmd_next;
            phase_reg <= phase_next;
            delay_reg <= delay_next;
            step_reg  <= step_next;
            shift_reg <= shift_next;
            rbyte_reg <= rbyte_next;
            ack_reg   <= ack_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            dir_reg   <= dir_next;
        end
    end

    // output register plus skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a pending output");

    a_busy_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_reg != CMD_NONE) |-> (delay_reg != '0))
        else $error("busy sequencer with empty hold count");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_reg == CMD_NONE) |-> (phase_reg == '0 && delay_reg == '0))
        else $error("idle sequencer with stale phase state");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.done_res) |-> !m_data.busy_res)
        else $error("done reported while still busy");

    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= last_phase(cmd_reg))
        else $error("phase index past end of sequence");

endmodule
